### sv/ahcf_pkg.sv
// Shared types and constants for the age histogram cutoff finder.
// No dependencies; imported by the divider, the top level and the testbench.
package ahcf_pkg;

    localparam int TIME_WIDTH    = 32;
    localparam int CUT_WIDTH     = 33;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_DAY   = 86400;

    // constant division by reciprocal multiply:
    // x / 3600 = (x >> 4) / 225, x / 86400 = (x >> 7) / 675
    localparam int QUOT_WIDTH = 12;
    localparam int HOUR_SHIFT = 4;
    localparam int HOUR_IN_W  = 18;   // hour dividends stay below 2^22
    localparam int HOUR_FRAC  = 26;
    localparam int DAY_SHIFT  = 7;
    localparam int RECIP_IN_W = 22;   // day dividends stay below 2^29
    localparam int DAY_FRAC   = 32;
    localparam int RECIP_W    = 23;
    localparam int PROD_W     = RECIP_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] HOUR_RECIP = RECIP_W'(298262);   // ceil(2^26 / 225)
    localparam logic [RECIP_W-1:0] DAY_RECIP  = RECIP_W'(6362915);  // ceil(2^32 / 675)

    // request into the shared divider
    typedef struct packed {
        logic                  start;
        logic                  by_day;
        logic [TIME_WIDTH-1:0] dividend;
    } div_req_t;

    // response from the shared divider
    typedef struct packed {
        logic                  done;
        logic [QUOT_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

### sv/ahcf_serial_div.sv
// Shared constant divider: hour or day index from an age, by reciprocal multiply.
// Depends on ahcf_pkg (div_req_t, div_rsp_t, reciprocal constants).
module ahcf_serial_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ahcf_pkg::div_req_t req,
    output ahcf_pkg::div_rsp_t rsp
);
    import ahcf_pkg::*;

    logic                  done_reg;
    logic [QUOT_WIDTH-1:0] quot_reg;

    logic [RECIP_IN_W-1:0] operand;
    logic [RECIP_W-1:0]    recip;
    logic [PROD_W-1:0]     prod;
    logic [QUOT_WIDTH-1:0] quot_next;

    // strip the power-of-two factor, then multiply by the rounded-up reciprocal
    always_comb
    begin
        if (req.by_day)
        begin
            operand = req.dividend[DAY_SHIFT +: RECIP_IN_W];
            recip   = DAY_RECIP;
        end
        else
        begin
            operand = RECIP_IN_W'(req.dividend[HOUR_SHIFT +: HOUR_IN_W]);
            recip   = HOUR_RECIP;
        end
        prod      = PROD_W'(operand) * PROD_W'(recip);
        quot_next = req.by_day ? prod[DAY_FRAC +: QUOT_WIDTH]
                               : prod[HOUR_FRAC +: QUOT_WIDTH];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= req.start;
            if (req.start)
            begin
                quot_reg <= quot_next;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

### sv/ahcf_bin_mem.sv
// Bin count memory: one write port, one read port, registered read data.
// No package dependency.
module ahcf_bin_mem #(
    parameter int DEPTH = 1100,
    parameter int AW    = 11,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/age_histogram_cutoff_finder.sv
// Top level: sequencer, counters and query scan of the age histogram.
// Depends on ahcf_pkg, ahcf_serial_div and ahcf_bin_mem.
//
// channel   direction  ports                          handshake
// -------   ---------  -----------------------------  ------------------------------
// request   in         req_type access_time max_size  taken when start & !busy
// result    out        cut_time was_query             valid for one cycle with done
// config    in         cfg_wdata                      written when cfg_we
//
// Steps, from the accepting edge to the result: a very-old add goes straight
// to the result; an add with a future timestamp reads the bin, then writes it;
// any other add first waits in ST_DIV for the shared divider's registered
// answer. A query checks the very-old count, then per bin scanned reads memory,
// then adds and compares, down to hour bin 0 at most. busy drops in the result
// cycle, so the next word can be taken on the edge that ends it. After reset a
// clearing pass writes zero to every bin, with busy high. The receiver cannot
// stall: a result word is presented once, on the cycle done is high.
module age_histogram_cutoff_finder #(
    parameter int HOUR_BINS   = 100,
    parameter int DAY_BINS    = 1000,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ahcf_pkg::TIME_WIDTH-1:0]      cfg_wdata,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic [ahcf_pkg::TIME_WIDTH-1:0]      access_time,
    input  logic [ahcf_pkg::TIME_WIDTH-1:0]      max_size,
    output logic                                 done,
    output logic signed [ahcf_pkg::CUT_WIDTH-1:0] cut_time,
    output logic                                 was_query
);
    import ahcf_pkg::*;

    // memory layout: hour bin i at address i, day bin i at HOUR_BINS+i,
    // so a descending address sweep goes oldest to newest
    localparam int NBINS     = HOUR_BINS + DAY_BINS;
    localparam int AW        = $clog2(NBINS);
    localparam int MAXW      = (COUNT_WIDTH > TIME_WIDTH) ? COUNT_WIDTH : TIME_WIDTH;
    localparam int SW        = MAXW + $clog2(NBINS + 2) + 1;
    localparam int HOUR_SPAN = HOUR_BINS * SEC_PER_HOUR;
    localparam int DAY_SPAN  = DAY_BINS * SEC_PER_DAY;
    localparam logic [CUT_WIDTH-1:0] OLD_SPAN =
        CUT_WIDTH'(DAY_BINS * SEC_PER_DAY + HOUR_BINS * SEC_PER_HOUR);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_FIRST,
        ST_Q_RD,
        ST_Q_ACC
    } state_t;

    state_t                       state_reg;
    logic [TIME_WIDTH-1:0]        ref_time_reg;
    logic [COUNT_WIDTH-1:0]       total_reg;
    logic [COUNT_WIDTH-1:0]       very_old_reg;
    logic [AW-1:0]                addr_reg;
    logic                         mem_we_reg;
    logic [AW-1:0]                mem_waddr_reg;
    logic [COUNT_WIDTH-1:0]       mem_wdata_reg;
    logic signed [SW-1:0]         excess_reg;
    logic signed [SW-1:0]         sum_reg;
    logic signed [CUT_WIDTH-1:0]  cut_reg;
    logic                         done_reg;
    logic signed [CUT_WIDTH-1:0]  cut_time_reg;
    logic                         was_query_reg;
    div_req_t                     div_req_reg;
    div_rsp_t                     div_rsp;
    logic [COUNT_WIDTH-1:0]       rdata;

    // combinational helpers
    logic                         future_ts;
    logic [TIME_WIDTH-1:0]        age;
    logic [TIME_WIDTH-1:0]        day_age;
    logic                         in_hours;
    logic                         in_days;
    logic signed [SW-1:0]         excess_next;
    logic signed [SW-1:0]         sum_next;
    logic signed [CUT_WIDTH-1:0]  cut_next;
    logic                         hit;

    always_comb
    begin
        future_ts   = (access_time > ref_time_reg);
        age         = ref_time_reg - access_time;
        // region is picked by compare, so the divider only sees in-range ages
        in_hours    = (age < TIME_WIDTH'(HOUR_SPAN));
        day_age     = age - TIME_WIDTH'(HOUR_SPAN);
        in_days     = (day_age < TIME_WIDTH'(DAY_SPAN));
        excess_next = $signed({{(SW - COUNT_WIDTH){1'b0}}, total_reg})
                    - $signed({{(SW - TIME_WIDTH){1'b0}}, max_size});
        sum_next    = sum_reg + $signed({{(SW - COUNT_WIDTH){1'b0}}, rdata});
        // stepping one bin newer moves the cutoff forward by the bin width
        cut_next    = cut_reg + ((addr_reg >= AW'(HOUR_BINS))
                    ? $signed(CUT_WIDTH'(SEC_PER_DAY))
                    : $signed(CUT_WIDTH'(SEC_PER_HOUR)));
        hit         = (sum_next >= excess_reg);
    end

    ahcf_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    ahcf_bin_mem #(
        .DEPTH (NBINS),
        .AW    (AW),
        .DW    (COUNT_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we_reg),
        .waddr (mem_waddr_reg),
        .wdata (mem_wdata_reg),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ref_time_reg  <= '0;
            total_reg     <= '0;
            very_old_reg  <= '0;
            addr_reg      <= '0;
            mem_we_reg    <= 1'b0;
            mem_waddr_reg <= '0;
            mem_wdata_reg <= '0;
            excess_reg    <= '0;
            sum_reg       <= '0;
            cut_reg       <= '0;
            done_reg      <= 1'b0;
            cut_time_reg  <= '0;
            was_query_reg <= 1'b0;
            div_req_reg   <= '0;
        end
        else
        begin
            mem_we_reg        <= 1'b0;
            done_reg          <= 1'b0;
            div_req_reg.start <= 1'b0;

            if (cfg_we)
            begin
                ref_time_reg <= cfg_wdata;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    mem_we_reg    <= 1'b1;
                    mem_waddr_reg <= addr_reg;
                    mem_wdata_reg <= '0;
                    if (addr_reg == AW'(NBINS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        addr_reg <= addr_reg + 1'b1;
                    end
                end

                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (req_type)
                        begin
                            excess_reg <= excess_next;
                            sum_reg    <= $signed({{(SW - COUNT_WIDTH){1'b0}}, very_old_reg});
                            cut_reg    <= $signed({1'b0, ref_time_reg} - OLD_SPAN);
                            addr_reg   <= AW'(NBINS - 1);
                            state_reg  <= ST_Q_FIRST;
                        end
                        else
                        begin
                            if (!(&total_reg))
                            begin
                                total_reg <= total_reg + 1'b1;
                            end
                            if (future_ts)
                            begin
                                addr_reg  <= '0;
                                state_reg <= ST_ADD_RD;
                            end
                            else if (in_hours)
                            begin
                                div_req_reg.start    <= 1'b1;
                                div_req_reg.by_day   <= 1'b0;
                                div_req_reg.dividend <= age;
                                state_reg            <= ST_DIV;
                            end
                            else if (in_days)
                            begin
                                div_req_reg.start    <= 1'b1;
                                div_req_reg.by_day   <= 1'b1;
                                div_req_reg.dividend <= day_age;
                                state_reg            <= ST_DIV;
                            end
                            else
                            begin
                                // older than every bin: no memory access
                                if (!(&very_old_reg))
                                begin
                                    very_old_reg <= very_old_reg + 1'b1;
                                end
                                done_reg      <= 1'b1;
                                cut_time_reg  <= '0;
                                was_query_reg <= 1'b0;
                            end
                        end
                    end
                end

                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_req_reg.by_day)
                        begin
                            addr_reg <= AW'(HOUR_BINS) + AW'(div_rsp.quotient);
                        end
                        else
                        begin
                            addr_reg <= AW'(div_rsp.quotient);
                        end
                        state_reg <= ST_ADD_RD;
                    end
                end

                ST_ADD_RD:
                begin
                    state_reg <= ST_ADD_WR;
                end

                ST_ADD_WR:
                begin
                    mem_we_reg    <= 1'b1;
                    mem_waddr_reg <= addr_reg;
                    mem_wdata_reg <= (&rdata) ? rdata : (rdata + 1'b1);
                    done_reg      <= 1'b1;
                    cut_time_reg  <= '0;
                    was_query_reg <= 1'b0;
                    state_reg     <= ST_IDLE;
                end

                ST_Q_FIRST:
                begin
                    if (sum_reg >= excess_reg)
                    begin
                        done_reg      <= 1'b1;
                        cut_time_reg  <= cut_reg;
                        was_query_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_Q_RD;
                    end
                end

                ST_Q_RD:
                begin
                    state_reg <= ST_Q_ACC;
                end

                ST_Q_ACC:
                begin
                    sum_reg <= sum_next;
                    cut_reg <= cut_next;
                    // after hour bin 0 the cutoff has reached the reference time
                    if (hit || (addr_reg == '0))
                    begin
                        done_reg      <= 1'b1;
                        cut_time_reg  <= cut_next;
                        was_query_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg - 1'b1;
                        state_reg <= ST_Q_RD;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign cut_time  = cut_time_reg;
    assign was_query = was_query_reg;

    // a result only closes out work that was in flight or just taken
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result word without a request in flight");

    // an accepted request either keeps the block busy or yields its result
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request did not start work");

    // add results carry a zero cutoff
    a_add_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !was_query) |-> (cut_time == '0))
        else $error("add result with nonzero cutoff");

    // bin writes stay inside the memory
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we_reg |-> (mem_waddr_reg <= AW'(NBINS - 1)))
        else $error("bin write outside memory");

endmodule

### tb/sv/ahcf_tb_pkg.sv
// Bin-count scoreboard for the age histogram cutoff finder testbench.
// Depends on ahcf_pkg for the time width, cutoff width and seconds constants.
package ahcf_tb_pkg;
    import ahcf_pkg::*;

    localparam bit REQ_ADD   = 1'b0;
    localparam bit REQ_QUERY = 1'b1;

    typedef struct packed {
        logic signed [CUT_WIDTH-1:0] cut_time;
        logic                        was_query;
    } result_word_t;

    class age_bin_scoreboard #(int HOURS = 100, int DAYS = 1000, int CNT_W = 32);
        bit [TIME_WIDTH-1:0] ref_time;
        longint              hour_cnt[HOURS];
        longint              day_cnt[DAYS];
        longint              very_old;
        longint              rec_total;
        result_word_t        expected_words[$];
        int                  errors;

        function new();
            ref_time  = '0;
            very_old  = 0;
            rec_total = 0;
            errors    = 0;
            foreach (hour_cnt[i])
                hour_cnt[i] = 0;
            foreach (day_cnt[i])
                day_cnt[i] = 0;
        endfunction

        function void set_reference(bit [TIME_WIDTH-1:0] t);
            ref_time = t;
        endfunction

        // counters stick at all ones
        function longint bump(longint c);
            if (c < (longint'(1) << CNT_W) - 1)
                return c + 1;
            return c;
        endfunction

        function void bin_record(bit [TIME_WIDTH-1:0] la);
            longint age;
            longint hr;
            longint dy;
            age = longint'({32'd0, ref_time}) - longint'({32'd0, la});
            rec_total = bump(rec_total);
            if (age < 0)
            begin
                hour_cnt[0] = bump(hour_cnt[0]);
                return;
            end
            hr = age / SEC_PER_HOUR;
            if (hr < HOURS)
            begin
                hour_cnt[hr] = bump(hour_cnt[hr]);
                return;
            end
            dy = (age - longint'(HOURS) * SEC_PER_HOUR) / SEC_PER_DAY;
            if (dy < DAYS)
                day_cnt[dy] = bump(day_cnt[dy]);
            else
                very_old = bump(very_old);
        endfunction

        // oldest bin first; exact sums
        function longint predict_cutoff(bit [TIME_WIDTH-1:0] ms);
            longint excess;
            longint sum;
            longint now;
            longint hour_span;
            excess    = rec_total - longint'({32'd0, ms});
            sum       = very_old;
            now       = longint'({32'd0, ref_time});
            hour_span = longint'(HOURS) * SEC_PER_HOUR;
            if (sum >= excess)
                return now - longint'(DAYS) * SEC_PER_DAY - hour_span;
            for (int i = DAYS - 1; i >= 0; i--)
            begin
                sum += day_cnt[i];
                if (sum >= excess)
                    return now - longint'(i) * SEC_PER_DAY - hour_span;
            end
            for (int i = HOURS - 1; i >= 0; i--)
            begin
                sum += hour_cnt[i];
                if (sum >= excess)
                    return now - longint'(i) * SEC_PER_HOUR;
            end
            return now;
        endfunction

        function void note_request(bit rq, bit [TIME_WIDTH-1:0] la,
                                   bit [TIME_WIDTH-1:0] ms);
            result_word_t w;
            longint       cut;
            if (rq == REQ_QUERY)
            begin
                cut         = predict_cutoff(ms);
                w.cut_time  = cut[CUT_WIDTH-1:0];
                w.was_query = 1'b1;
            end
            else
            begin
                bin_record(la);
                w.cut_time  = '0;
                w.was_query = 1'b0;
            end
            expected_words.push_back(w);
        endfunction

        function void check_result(logic signed [CUT_WIDTH-1:0] cut, logic q);
            result_word_t w;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: cut_time=%0d was_query=%0b", cut, q);
                errors++;
                return;
            end
            w = expected_words.pop_front();
            if (q !== w.was_query)
            begin
                $error("was_query: expected %0b, actual %0b", w.was_query, q);
                errors++;
            end
            if (cut !== w.cut_time)
            begin
                $error("cut_time: expected %0d, actual %0d", w.cut_time, cut);
                errors++;
            end
        endfunction
    endclass

endpackage

### tb/sv/tb_top.sv
// Testbench top for age_histogram_cutoff_finder: directed and random words.
// Depends on ahcf_pkg, ahcf_tb_pkg and the block's RTL.
module tb_top;
    import ahcf_pkg::*;
    import ahcf_tb_pkg::*;

    localparam int HOUR_BINS   = 100;
    localparam int DAY_BINS    = 1000;
    localparam int COUNT_WIDTH = 32;
    localparam int HOUR_SPAN   = HOUR_BINS * SEC_PER_HOUR;   // end of the hour bins
    localparam int DAY_SPAN    = DAY_BINS * SEC_PER_DAY;     // width of the day bins
    // longest quiet stretch: clearing pass plus a full query scan, with margin
    localparam int STALL_LIMIT = 16000;
    localparam int PHASE_WORDS = 84;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_we      = 1'b0;
    logic [TIME_WIDTH-1:0]        cfg_wdata   = '0;
    logic                         start       = 1'b0;
    logic                         req_type    = REQ_ADD;
    logic [TIME_WIDTH-1:0]        access_time = '0;
    logic [TIME_WIDTH-1:0]        max_size    = '0;
    logic                         busy;
    logic                         done;
    logic signed [CUT_WIDTH-1:0]  cut_time;
    logic                         was_query;

    age_bin_scoreboard #(HOUR_BINS, DAY_BINS, COUNT_WIDTH) sb;

    int unsigned accept_cnt   = 0;
    int          stall_cycles = 0;
    bit          no_gaps      = 1'b0;

    always #10 clk = ~clk;

    age_histogram_cutoff_finder #(
        .HOUR_BINS   (HOUR_BINS),
        .DAY_BINS    (DAY_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .access_time (access_time),
        .max_size    (max_size),
        .done        (done),
        .cut_time    (cut_time),
        .was_query   (was_query)
    );

    // Monitor: everything is sampled on the rising edge. A config write updates
    // the model's reference time, an accepted request word runs the predictor,
    // and a done strobe is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_reference(cfg_wdata);
            if (start && !busy)
            begin
                sb.note_request(req_type, access_time, max_size);
                accept_cnt <= accept_cnt + 1;
            end
            if (done)
                sb.check_result(cut_time, was_query);
        end
    end

    // Watchdog: counts edges with neither an accepted request nor a result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("age_histogram_cutoff_finder test failed");
            $finish;
        end
    end

    // Present one request word at the current falling edge and hold it until
    // the monitor has seen it taken. Returns on a falling edge with start high.
    task automatic send_word(bit rq, bit [TIME_WIDTH-1:0] la, bit [TIME_WIDTH-1:0] ms);
        int unsigned target;
        target      = accept_cnt + 1;
        req_type    = rq;
        access_time = la;
        max_size    = ms;
        start       = 1'b1;
        do
            @(negedge clk);
        while (accept_cnt != target);
    endtask

    // Random sender bubbles, with start low; runs without any occur naturally.
    task automatic idle_gap();
        if (!no_gaps && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    // Stop sending and wait for every outstanding result word.
    task automatic drain();
        start = 1'b0;
        while (sb.expected_words.size() != 0)
            @(negedge clk);
    endtask

    // The reference time only changes with the block idle: queue empty, busy low
    // (busy also covers the clearing pass after reset).
    task automatic write_reference(bit [TIME_WIDTH-1:0] t);
        drain();
        while (busy)
            @(negedge clk);
        cfg_wdata = t;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Access times spread over every region of the histogram, plus bin edges,
    // future stamps and fully random values.
    function automatic bit [TIME_WIDTH-1:0] pick_access(bit [TIME_WIDTH-1:0] now);
        case ($urandom_range(0, 10))
            0:       return now + $urandom_range(1, 5000);
            1, 2, 3: return now - $urandom_range(0, HOUR_SPAN - 1);
            4, 5, 6: return now - HOUR_SPAN - $urandom_range(0, DAY_SPAN - 1);
            7:       return now - HOUR_SPAN - DAY_SPAN - $urandom_range(0, 1000000);
            8:       return now - $urandom_range(0, HOUR_BINS) * SEC_PER_HOUR
                            + $urandom_range(0, 1);
            9:       return now - HOUR_SPAN - $urandom_range(0, DAY_BINS) * SEC_PER_DAY
                            + $urandom_range(0, 1);
            default: return $urandom();
        endcase
    endfunction

    // Size limits: half the time an excess between 1 and the record total so the scan
    // stops somewhere inside the histogram; also zero, all ones and noise.
    function automatic bit [TIME_WIDTH-1:0] pick_limit();
        bit [TIME_WIDTH-1:0] tot;
        tot = 32'(sb.rec_total);
        case ($urandom_range(0, 9))
            0:             return '0;
            1:             return '1;
            2:             return $urandom();
            3, 4, 5, 6, 7: return (tot == 0) ? '0 : tot - $urandom_range(1, tot);
            default:       return tot - $urandom_range(0, 3);
        endcase
    endfunction

    task automatic random_phase(bit [TIME_WIDTH-1:0] now, int n);
        write_reference(now);
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 15)
                send_word(REQ_QUERY, $urandom(), pick_limit());
            else
                send_word(REQ_ADD, pick_access(now), $urandom());
            idle_gap();
        end
    endtask

    // Directed words: every bin edge, future stamps, each query branch, negative
    // cutoff and both extremes of the reference time.
    task automatic directed_words();
        bit [TIME_WIDTH-1:0] r;
        r = 32'd100_000_000;
        write_reference(r);
        send_word(REQ_ADD, r + 1, '1);                              // future -> hour 0
        send_word(REQ_ADD, '1, '0);                                 // far future
        send_word(REQ_ADD, r, '0);                                  // age zero
        send_word(REQ_ADD, r - (SEC_PER_HOUR - 1), '0);             // last second of hour 0
        send_word(REQ_ADD, r - SEC_PER_HOUR, '0);                   // hour 1
        send_word(REQ_ADD, r - (HOUR_SPAN - 1), '0);                // last hour bin
        send_word(REQ_ADD, r - HOUR_SPAN, '0);                      // day 0
        send_word(REQ_ADD, r - HOUR_SPAN - (SEC_PER_DAY - 1), '0);  // still day 0
        send_word(REQ_ADD, r - HOUR_SPAN - SEC_PER_DAY, '0);        // day 1
        send_word(REQ_ADD, r - HOUR_SPAN - (DAY_SPAN - 1), '0);     // last day bin
        send_word(REQ_ADD, r - HOUR_SPAN - DAY_SPAN, '0);           // very old
        send_word(REQ_ADD, '0, '0);                                 // very old
        send_word(REQ_QUERY, '1, 32'd10);   // excess met by the very-old count
        send_word(REQ_QUERY, '0, 32'd9);    // stops in the last day bin
        send_word(REQ_QUERY, '0, 32'd0);    // full scan down to hour 0
        send_word(REQ_QUERY, '0, '1);       // negative excess
        send_word(REQ_QUERY, '0, 32'd12);   // zero excess
        write_reference('0);
        send_word(REQ_QUERY, '0, '1);       // cutoff below zero
        send_word(REQ_ADD, '0, '0);
        send_word(REQ_ADD, 32'd5, '0);
        send_word(REQ_QUERY, '1, '0);
        write_reference('1);
        send_word(REQ_ADD, '0, '1);         // largest possible age
        send_word(REQ_QUERY, '0, 32'd1);
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        directed_words();
        random_phase($urandom(), PHASE_WORDS);
        random_phase('1, PHASE_WORDS);
        random_phase(32'(HOUR_SPAN + DAY_SPAN) + $urandom_range(0, 2000000), PHASE_WORDS);
        random_phase('0, PHASE_WORDS / 2);
        // closing stretch runs back to back
        no_gaps = 1'b1;
        random_phase(32'd123_456_789, PHASE_WORDS);

        drain();
        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0)
            $display("age_histogram_cutoff_finder test passed");
        else
            $display("age_histogram_cutoff_finder test failed");
        $finish;
    end

endmodule

### files.f
sv/ahcf_pkg.sv
sv/ahcf_serial_div.sv
sv/ahcf_bin_mem.sv
sv/age_histogram_cutoff_finder.sv
tb/sv/ahcf_tb_pkg.sv
tb/sv/tb_top.sv
